// File: hw/rtl/skset_pkg.sv
package skset_pkg;

    localparam int unsigned MODE_W    = 2;
    localparam int unsigned FIELD_W   = 7;
    localparam int unsigned KEY_PORT_W = 64;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_FIND   = 2'd2,
        MODE_SPARE  = 2'd3
    } t_mode;

    // shift command broadcast to every cell in the update cycle
    typedef struct packed {
        logic ins;   // open a slot at the boundary and shift later entries up
        logic del;   // drop the boundary entry and shift later entries down
    } t_cell_ctl;

endpackage

// File: hw/rtl/sorted_key_set.sv
// sorted_key_set: a set of distinct keys kept in ascending order
// request channel: i_in_valid / o_in_ready with i_mode (add, remove, find)
// and i_key; one result request follows each input on o_out_valid /
// i_out_ready carrying presence, position, full status and new count
// capacity register: written on i_cfg_valid / o_cfg_ready, always ready;
// the user must write it only while the block is idle; the block does not enforce this
// the store is a row of cells, one entry each; at the accept edge every
// used cell compares its key with the incoming key, in the next cycle the
// boundary cell is found from neighbor compares, and once the result register
// is free the cells from the boundary on shift by one place at once for an insert or a delete
// the result is registered in the update step, after the accept step
// a new request is taken only after the compare then shift steps of the
// previous one complete; the result register lets a new request enter
// while the previous result still waits
// a stalled receiver holds the next update until the result register frees
// reset: count cleared, capacity back to 64, entry contents left unknown
module sorted_key_set #(
    parameter int unsigned MAX_ENTRIES = 64,
    parameter int unsigned KEY_BYTES   = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [skset_pkg::MODE_W-1:0]          i_mode,
    input  logic [skset_pkg::KEY_PORT_W-1:0]      i_key,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_was_present,
    output logic [skset_pkg::FIELD_W-1:0]         o_position,
    output logic                                  o_status,
    output logic [skset_pkg::FIELD_W-1:0]         o_entry_count,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [skset_pkg::FIELD_W-1:0]         i_cfg_capacity
);
    import skset_pkg::*;

    localparam int unsigned KEY_W = 8 * KEY_BYTES;
    localparam int unsigned CW    = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned MW    = (CW > FIELD_W) ? CW : FIELD_W;
    localparam logic [FIELD_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic {
        S_IDLE,
        S_UPD
    } t_state;

    t_state             r_state;
    logic [MODE_W-1:0]  r_mode;
    logic [KEY_W-1:0]   r_key;
    logic [CW-1:0]      r_count;
    logic [FIELD_W-1:0] r_cap;

    logic               r_out_valid;
    logic               r_was_present;
    logic [FIELD_W-1:0] r_position;
    logic               r_status;
    logic [FIELD_W-1:0] r_entry_count;

    logic [KEY_W-1:0]   in_key;
    logic               accept;
    logic               upd_go;
    logic               present;
    logic               full;
    logic               do_ins;
    logic               do_del;
    logic [CW-1:0]      pos;
    logic [CW-1:0]      n_count;
    t_cell_ctl          ctl;

    logic [KEY_W-1:0]       cell_key [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] cell_lt;
    logic [MAX_ENTRIES-1:0] cell_eq;
    logic [MAX_ENTRIES-1:0] cell_bnd;

    // key bits above the configured byte count are ignored
    assign in_key = i_key[KEY_W-1:0];

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid & o_in_ready;
    assign upd_go     = (r_state == S_UPD) & (~r_out_valid | i_out_ready);
    assign o_cfg_ready = 1'b1;

    // cell row
    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        logic             lt_left;
        logic [KEY_W-1:0] left_key;
        logic [KEY_W-1:0] right_key;

        if (i == 0) begin : g_first
            assign lt_left  = 1'b1;
            assign left_key = cell_key[i];
        end else begin : g_mid_l
            assign lt_left  = cell_lt[i-1];
            assign left_key = cell_key[i-1];
        end

        if (i == MAX_ENTRIES - 1) begin : g_last
            assign right_key = cell_key[i];
        end else begin : g_mid_r
            assign right_key = cell_key[i+1];
        end

        skset_cell #(
            .KEY_W (KEY_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_load      (accept),
            .i_used      (CW'(i) < r_count),
            .i_key       (in_key),
            .i_new_key   (r_key),
            .i_lt_left   (lt_left),
            .i_left_key  (left_key),
            .i_right_key (right_key),
            .i_ctl       (ctl),
            .o_key       (cell_key[i]),
            .o_lt        (cell_lt[i]),
            .o_eq        (cell_eq[i]),
            .o_bnd       (cell_bnd[i])
        );
    end

    // boundary one-hot to index; last cell used and below the key means position = row length
    always_comb begin
        pos = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (cell_bnd[i]) begin
                pos = pos | CW'(i);
            end
        end
        if (cell_lt[MAX_ENTRIES-1]) begin
            pos = CW'(MAX_ENTRIES);
        end
    end

    assign present = |cell_eq;
    // capacity above the row length saturates to the row length
    assign full    = (MW'(r_count) >= MW'(r_cap)) || (r_count == CW'(MAX_ENTRIES));

    always_comb begin
        do_ins = 1'b0;
        do_del = 1'b0;
        case (t_mode'(r_mode))
            MODE_ADD:    do_ins = ~present & ~full;
            MODE_REMOVE: do_del = present;
            default: begin
                do_ins = 1'b0;
                do_del = 1'b0;
            end
        endcase
    end

    assign ctl.ins = upd_go & do_ins;
    assign ctl.del = upd_go & do_del;

    always_comb begin
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + CW'(1);
        end else if (do_del) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_capacity;
            end
            // a new result takes the register in the cycle the old one leaves
            if (upd_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (upd_go) begin
                        r_state       <= S_IDLE;
                        r_count       <= n_count;
                        r_was_present <= present;
                        r_position    <= FIELD_W'(pos);
                        r_status      <= (t_mode'(r_mode) == MODE_ADD) & ~present & full;
                        r_entry_count <= FIELD_W'(n_count);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        if (accept) begin
            r_mode <= i_mode;
            r_key  <= in_key;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_was_present = r_was_present;
    assign o_position    = r_position;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;

endmodule

// File: hw/rtl/skset_cell.sv
module skset_cell #(
    parameter int unsigned KEY_W = 64
) (
    input  logic                  i_clk,
    input  logic                  i_load,
    input  logic                  i_used,
    input  logic [KEY_W-1:0]      i_key,
    input  logic [KEY_W-1:0]      i_new_key,
    input  logic                  i_lt_left,
    input  logic [KEY_W-1:0]      i_left_key,
    input  logic [KEY_W-1:0]      i_right_key,
    input  skset_pkg::t_cell_ctl  i_ctl,
    output logic [KEY_W-1:0]      o_key,
    output logic                  o_lt,
    output logic                  o_eq,
    output logic                  o_bnd
);
    import skset_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;
    logic             r_lt;
    logic             r_eq;

    // first entry not below the search key
    assign o_bnd = i_lt_left & ~r_lt;

    always_comb begin
        n_key = r_key;
        if (i_ctl.ins && !r_lt) begin
            n_key = o_bnd ? i_new_key : i_left_key;
        end else if (i_ctl.del && !r_lt) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (i_load) begin
            r_lt <= i_used & (r_key < i_key);
            r_eq <= i_used & (r_key == i_key);
        end
    end

    assign o_key = r_key;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule
